// ===== rtl/ppid_pkg.sv =====
// ============================================================================
// ppid_pkg
// Shared types, widths and register codes of the positional PID controller.
// ============================================================================
package ppid_pkg;

    // Fixed-point format of the gains
    localparam int GAIN_FRAC_BITS = 8;

    // Field and state widths
    localparam int GAIN_W    = 16;
    localparam int VALUE_W   = 16;
    localparam int ERR_W     = VALUE_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int ILIM_W    = 24;
    localparam int SUM_W     = ILIM_W + 1;
    localparam int OLIM_W    = 15;
    localparam int DRIVE_W   = OLIM_W + 1;

    // Product and accumulator widths (exact, no wrap)
    localparam int PROD_P_W  = GAIN_W + ERR_W;
    localparam int PROD_I_W  = GAIN_W + SUM_W;
    localparam int PROD_D_W  = GAIN_W + DIFF_W;
    localparam int ACC_W     = PROD_I_W + 2;
    localparam int SHIFT_W   = ACC_W - GAIN_FRAC_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ILIM_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4
    } cfg_index_t;

    // Register file contents
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic        [ILIM_W-1:0] integral_limit;
        logic        [OLIM_W-1:0] output_limit;
    } cfg_t;

    // Error stage result
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
    } err_stage_t;

    // Product stage result
    typedef struct packed {
        logic signed [PROD_P_W-1:0] p;
        logic signed [PROD_I_W-1:0] i;
        logic signed [PROD_D_W-1:0] d;
    } prod_t;

endpackage

// ===== rtl/ppid_cfg.sv =====
// ============================================================================
// ppid_cfg
// Configuration register file: gains and limits, written through a plain port.
// ============================================================================
module ppid_cfg
    import ppid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAIN_P:         cfg_next.gain_p         = $signed(cfg_data[GAIN_W-1:0]);
                CFG_GAIN_I:         cfg_next.gain_i         = $signed(cfg_data[GAIN_W-1:0]);
                CFG_GAIN_D:         cfg_next.gain_d         = $signed(cfg_data[GAIN_W-1:0]);
                CFG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[ILIM_W-1:0];
                CFG_OUTPUT_LIMIT:   cfg_next.output_limit   = cfg_data[OLIM_W-1:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_limit <= '1;
            cfg_reg.output_limit   <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ppid_error.sv =====
// ============================================================================
// ppid_error
// Error, clamped integral and derivative difference; owns the loop state.
// ============================================================================
module ppid_error
    import ppid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic signed [VALUE_W-1:0] set_value,
    input  logic signed [VALUE_W-1:0] actual_value,
    input  logic        [ILIM_W-1:0]  integral_limit,
    output err_stage_t                stage
);

    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [SUM_W-1:0]  error_sum_next;
    logic signed [ERR_W-1:0]  last_error_reg;
    err_stage_t               stage_reg;
    err_stage_t               stage_next;

    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W:0]    sum_raw;
    logic signed [SUM_W:0]    lim_pos;
    logic signed [SUM_W:0]    lim_neg;

    // Error and integral with anti-windup clamp
    always_comb
    begin
        err     = ERR_W'(set_value) - ERR_W'(actual_value);
        sum_raw = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err);
        lim_pos = $signed({2'b00, integral_limit});
        lim_neg = -lim_pos;
        priority if (sum_raw > lim_pos)
        begin
            error_sum_next = lim_pos[SUM_W-1:0];
        end
        else if (sum_raw < lim_neg)
        begin
            error_sum_next = lim_neg[SUM_W-1:0];
        end
        else
        begin
            error_sum_next = sum_raw[SUM_W-1:0];
        end
        stage_next.err  = err;
        stage_next.sum  = error_sum_next;
        stage_next.diff = DIFF_W'(err) - DIFF_W'(last_error_reg);
    end

    // Loop state advances once per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else if (load)
        begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= err;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

    // The staged difference uses the error of the previous transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (stage_reg.diff ==
                  DIFF_W'(stage_reg.err) - DIFF_W'($past(last_error_reg))))
        else $error("derivative difference does not use the previous error");

    // The stored integral matches the one sent down the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (error_sum_reg == stage_reg.sum))
        else $error("integral state and staged integral disagree");

    // Loop state only moves with a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> ($stable(error_sum_reg) && $stable(last_error_reg)))
        else $error("loop state changed without a transaction");

endmodule

// ===== rtl/ppid_mult.sv =====
// ============================================================================
// ppid_mult
// Product stage: the three gain multiplications, each registered.
// ============================================================================
module ppid_mult
    import ppid_pkg::*;
(
    input  logic       clk,
    input  logic       load,
    input  cfg_t       cfg,
    input  err_stage_t stage,
    output prod_t      prod
);

    prod_t prod_reg;
    prod_t prod_next;

    // Three independent exact products
    always_comb
    begin
        prod_next.p = PROD_P_W'(cfg.gain_p) * PROD_P_W'(stage.err);
        prod_next.i = PROD_I_W'(cfg.gain_i) * PROD_I_W'(stage.sum);
        prod_next.d = PROD_D_W'(cfg.gain_d) * PROD_D_W'(stage.diff);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/ppid_out.sv =====
// ============================================================================
// ppid_out
// Output stage: sum of products, floor shift and output clamp.
// ============================================================================
module ppid_out
    import ppid_pkg::*;
(
    input  logic                      clk,
    input  logic                      load,
    input  prod_t                     prod,
    input  logic        [OLIM_W-1:0]  output_limit,
    output logic signed [DRIVE_W-1:0] drive
);

    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;

    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_shift;
    logic signed [SHIFT_W-1:0] scaled;
    logic signed [SHIFT_W-1:0] lim_pos;
    logic signed [SHIFT_W-1:0] lim_neg;

    // Arithmetic shift rounds toward minus infinity.
    always_comb
    begin
        acc       = ACC_W'(prod.p) + ACC_W'(prod.i) + ACC_W'(prod.d);
        acc_shift = acc >>> GAIN_FRAC_BITS;
        scaled    = acc_shift[SHIFT_W-1:0];
        lim_pos   = $signed({{(SHIFT_W-OLIM_W){1'b0}}, output_limit});
        lim_neg   = -lim_pos;
        priority if (scaled > lim_pos)
        begin
            drive_next = lim_pos[DRIVE_W-1:0];
        end
        else if (scaled < lim_neg)
        begin
            drive_next = lim_neg[DRIVE_W-1:0];
        end
        else
        begin
            drive_next = scaled[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

// ===== rtl/positional_pid_controller.sv =====
// ============================================================================
// positional_pid_controller
// Positional PID step with integral anti-windup and Q8.8 gains.
// ============================================================================
// Usage:
//   Input stream s_axis: one transaction carries a setpoint and a measurement.
//   Output stream m_axis: one transaction per input carries the drive value.
//   Configuration: cfg_we/cfg_index/cfg_data write gains and limits; write
//   only while no transaction is in flight.
//   The datapath is four register stages: input, error/integral, products,
//   and sum/shift/clamp into the output register; a result is registered in
//   each of them in that order. One transaction can be accepted every cycle
//   unless a stalled receiver has filled the pipeline; the three multipliers
//   in the product stage set the cycle time.
//   Each stage advances whenever it is empty or the stage after it advances,
//   so a stalled receiver only blocks the input once all four stages hold
//   data. Results leave in input order with none dropped.
//   Reset clears all stage valid flags, the integral and the last error, sets
//   the gains to zero and both limits to their maximum.
// ============================================================================
module positional_pid_controller
    import ppid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [15:0] set_value, [31:16] actual_value
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [15:0] drive
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    err_stage_t err_stage;
    prod_t      prod;

    logic signed [VALUE_W-1:0] set_value_reg;
    logic signed [VALUE_W-1:0] actual_value_reg;
    logic signed [DRIVE_W-1:0] drive;

    logic in_valid_reg,   in_valid_next;
    logic err_valid_reg,  err_valid_next;
    logic prod_valid_reg, prod_valid_next;
    logic out_valid_reg,  out_valid_next;

    logic en_out;
    logic en_prod;
    logic en_err;
    logic en_in;

    // Stage enables: a stage moves when empty or when its successor moves.
    always_comb
    begin
        en_out  = !out_valid_reg  || m_axis_tready;
        en_prod = !prod_valid_reg || en_out;
        en_err  = !err_valid_reg  || en_prod;
        en_in   = !in_valid_reg   || en_err;

        in_valid_next   = en_in   ? s_axis_tvalid  : in_valid_reg;
        err_valid_next  = en_err  ? in_valid_reg   : err_valid_reg;
        prod_valid_next = en_prod ? err_valid_reg  : prod_valid_reg;
        out_valid_next  = en_out  ? prod_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            err_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            err_valid_reg  <= err_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (en_in && s_axis_tvalid)
        begin
            set_value_reg    <= $signed(s_axis_tdata[15:0]);
            actual_value_reg <= $signed(s_axis_tdata[31:16]);
        end
    end

    ppid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppid_error u_error (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (en_err && in_valid_reg),
        .set_value      (set_value_reg),
        .actual_value   (actual_value_reg),
        .integral_limit (cfg.integral_limit),
        .stage          (err_stage)
    );

    ppid_mult u_mult (
        .clk   (clk),
        .load  (en_prod && err_valid_reg),
        .cfg   (cfg),
        .stage (err_stage),
        .prod  (prod)
    );

    ppid_out u_out (
        .clk          (clk),
        .load         (en_out && prod_valid_reg),
        .prod         (prod),
        .output_limit (cfg.output_limit),
        .drive        (drive)
    );

    assign s_axis_tready = en_in;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = drive;

    // The input only stalls when every stage is full and the output is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && err_valid_reg && prod_valid_reg &&
                            out_valid_reg && !m_axis_tready))
        else $error("input stalled while the pipeline has room");

    // The clamp is symmetric, so the most negative code never appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != 16'h8000))
        else $error("drive outside the symmetric clamp range");

endmodule

// ===== tb/sv/tb_positional_pid_controller.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_positional_pid_controller
// Self-checking testbench for the positional PID controller.
// ============================================================================
// A short table of directed transactions and register writes covers the gain
// and limit extremes, floor rounding, the zero limits, the ignored register
// index and over-wide register data. It is followed by random phases, each
// with fresh register settings. Every accepted transaction is run through a
// local PID model, and each drive value that leaves the block is compared
// with the oldest expected value. Both streams idle at random, the receiver
// holds off once long enough to back up the pipeline, and one phase runs
// with no idling at all.
// ============================================================================
module tb_positional_pid_controller;
    import ppid_pkg::*;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE  = 3'd7;

    localparam int IDLE_PERCENT    = 27;
    localparam int HOLD_CYCLES     = 64;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic [CFG_IDX_W-1:0]        index;
        logic [CFG_DATA_W-1:0]       data;
        logic signed [VALUE_W-1:0]   setpoint;
        logic signed [VALUE_W-1:0]   measured;
        bit                          has_drive;
        logic signed [DRIVE_W-1:0]   drive;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // [15:0] set_value, [31:16] actual_value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;   // [15:0] drive
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Model copy of the registers and of the controller state
    logic signed [GAIN_W-1:0] gain_p_m;
    logic signed [GAIN_W-1:0] gain_i_m;
    logic signed [GAIN_W-1:0] gain_d_m;
    logic        [ILIM_W-1:0] integral_limit_m;
    logic        [OLIM_W-1:0] output_limit_m;
    logic signed [SUM_W-1:0]  integral_sum;
    logic signed [ERR_W-1:0]  prev_error;

    logic signed [DRIVE_W-1:0] pending_drives[$];
    stim_row_t                 directed_rows[$];

    int mismatches;
    bit no_idle;
    int holds_asked;
    int holds_done;
    int hold_left;

    positional_pid_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run limit, far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    // One controller step: updates the integral and the last error and
    // returns the clamped drive value.
    function automatic logic signed [DRIVE_W-1:0] pid_next_drive(
        input logic signed [VALUE_W-1:0] setpoint,
        input logic signed [VALUE_W-1:0] measured
    );
        longint err;
        longint sum;
        longint acc;
        longint lim_i;
        longint lim_o;
        begin
            lim_i = longint'(integral_limit_m);
            lim_o = longint'(output_limit_m);
            err   = longint'(setpoint) - longint'(measured);
            sum   = longint'(integral_sum) + err;
            if (sum > lim_i)
                sum = lim_i;
            else if (sum < -lim_i)
                sum = -lim_i;
            acc = longint'(gain_p_m) * err + longint'(gain_i_m) * sum
                + longint'(gain_d_m) * (err - longint'(prev_error));
            // Arithmetic shift floors toward minus infinity
            acc = acc >>> GAIN_FRAC_BITS;
            if (acc > lim_o)
                acc = lim_o;
            else if (acc < -lim_o)
                acc = -lim_o;
            integral_sum = sum[SUM_W-1:0];
            prev_error   = err[ERR_W-1:0];
            return acc[DRIVE_W-1:0];
        end
    endfunction

    // Register write as the block sees it: unknown indexes are dropped and
    // only the low bits of each register are kept.
    function automatic void apply_register(
        input logic [CFG_IDX_W-1:0]  index,
        input logic [CFG_DATA_W-1:0] data
    );
        case (index)
            CFG_GAIN_P:         gain_p_m = data[GAIN_W-1:0];
            CFG_GAIN_I:         gain_i_m = data[GAIN_W-1:0];
            CFG_GAIN_D:         gain_d_m = data[GAIN_W-1:0];
            CFG_INTEGRAL_LIMIT: integral_limit_m = data[ILIM_W-1:0];
            CFG_OUTPUT_LIMIT:   output_limit_m = data[OLIM_W-1:0];
            default:            ;
        endcase
    endfunction

    function automatic void add_item(
        input logic signed [VALUE_W-1:0] setpoint,
        input logic signed [VALUE_W-1:0] measured
    );
        stim_row_t row;
        begin
            row = '{ROW_ITEM, '0, '0, setpoint, measured, 1'b0, '0};
            directed_rows.push_back(row);
        end
    endfunction

    function automatic void add_item_drive(
        input logic signed [VALUE_W-1:0] setpoint,
        input logic signed [VALUE_W-1:0] measured,
        input logic signed [DRIVE_W-1:0] drive
    );
        stim_row_t row;
        begin
            row = '{ROW_ITEM, '0, '0, setpoint, measured, 1'b1, drive};
            directed_rows.push_back(row);
        end
    endfunction

    function automatic void add_write(
        input logic [CFG_IDX_W-1:0]  index,
        input logic [CFG_DATA_W-1:0] data
    );
        stim_row_t row;
        begin
            row = '{ROW_WRITE, index, data, '0, '0, 1'b0, '0};
            directed_rows.push_back(row);
        end
    endfunction

    // Number of idle cycles before the next transaction
    function automatic int idle_gap();
        int gap;
        begin
            gap = 0;
            while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
                gap++;
            return gap;
        end
    endfunction

    // Gain value, small most of the time, with random bits above the register
    function automatic logic [CFG_DATA_W-1:0] random_gain();
        logic [GAIN_W-1:0] gain;
        begin
            case ($urandom_range(4))
                0:       gain = GAIN_W'($urandom);
                1:       gain = '0;
                2:       gain = GAIN_W'($urandom_range(600));
                default: gain = GAIN_W'($signed($urandom_range(1200)) - 600);
            endcase
            return {8'($urandom), gain};
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_integral_limit();
        begin
            case ($urandom_range(5))
                0:       return CFG_DATA_W'($urandom);
                1:       return '1;
                2:       return '0;
                default: return CFG_DATA_W'($urandom_range(4000));
            endcase
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_output_limit();
        logic [OLIM_W-1:0] lim;
        begin
            case ($urandom_range(4))
                0:       lim = '1;
                1:       lim = '0;
                2:       lim = OLIM_W'($urandom_range(200));
                default: lim = OLIM_W'($urandom);
            endcase
            return {9'($urandom), lim};
        end
    endfunction

    // Register write, only issued while nothing is in flight
    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  index,
        input logic [CFG_DATA_W-1:0] data
    );
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        apply_register(index, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stop offering transactions and wait until every drive value is back
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
    endtask

    // Offer one transaction and record its expected drive once accepted.
    // A transaction that follows without a gap keeps tvalid high.
    task automatic send_sample(
        input logic signed [VALUE_W-1:0] setpoint,
        input logic signed [VALUE_W-1:0] measured,
        input bit                        has_drive,
        input logic signed [DRIVE_W-1:0] drive
    );
        int                        gap;
        logic signed [DRIVE_W-1:0] predicted;
        begin
            gap = idle_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {measured, setpoint};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            predicted = pid_next_drive(setpoint, measured);
            pending_drives.push_back(has_drive ? drive : predicted);
        end
    endtask

    task automatic note_mismatch(
        input string                     what,
        input logic signed [DRIVE_W-1:0] expected,
        input logic signed [DRIVE_W-1:0] actual
    );
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s at %0t ns: expected %0d, got %0d",
                     what, $time, expected, actual);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (holds_asked != holds_done)
        begin
            holds_done = holds_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare every drive value that leaves the block with the oldest one due
    always @(posedge clk)
    begin : drive_check
        logic signed [DRIVE_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_drives.size() == 0)
            begin
                note_mismatch("unexpected drive", '0, m_axis_tdata);
            end
            else
            begin
                want = pending_drives.pop_front();
                if (m_axis_tdata !== want)
                    note_mismatch("drive mismatch", want, m_axis_tdata);
            end
        end
    end

    // Stimulus: reset, directed table, then random phases
    initial
    begin : stimulus
        int                        phase;
        int                        k;
        logic signed [VALUE_W-1:0] setpoint;
        logic signed [VALUE_W-1:0] measured;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        no_idle       = 1'b0;
        holds_asked   = 0;

        // Reset values of the registers and the state
        gain_p_m         = '0;
        gain_i_m         = '0;
        gain_d_m         = '0;
        integral_limit_m = '1;
        output_limit_m   = '1;
        integral_sum     = '0;
        prev_error       = '0;

        // Gains are zero after reset, so the drive is zero
        add_item_drive(16'sh7FFF, -16'sh8000, 16'sd0);
        add_item_drive(-16'sh8000, 16'sh7FFF, 16'sd0);
        // Unity proportional gain: drive follows the error up to the limit
        add_write(CFG_GAIN_P, 24'h000100);
        add_item_drive(16'sh7FFF, -16'sh8000, 16'sd32767);
        add_item_drive(-16'sh8000, 16'sh7FFF, -16'sd32767);
        add_item_drive(16'sd100, 16'sd40, 16'sd60);
        // Half gain shows the shift flooring toward minus infinity
        add_write(CFG_GAIN_P, 24'h000080);
        add_item_drive(16'sd0, 16'sd1, -16'sd1);
        add_item_drive(16'sd1, 16'sd0, 16'sd0);
        add_item_drive(16'sd3, 16'sd0, 16'sd1);
        add_item_drive(16'sd0, 16'sd3, -16'sd2);
        // Most negative gain
        add_write(CFG_GAIN_P, 24'h008000);
        add_item_drive(16'sd1, 16'sd0, -16'sd128);
        add_item_drive(-16'sh8000, 16'sh7FFF, 16'sd32767);
        add_item_drive(16'sh7FFF, -16'sh8000, -16'sd32767);
        // Over-wide register data keeps only the low bits
        add_write(CFG_GAIN_P, 24'hFF0100);
        add_write(CFG_OUTPUT_LIMIT, 24'hFF8064);
        add_item_drive(16'sd1000, 16'sd0, 16'sd100);
        add_item_drive(-16'sd1000, 16'sd0, -16'sd100);
        add_item_drive(16'sd50, 16'sd0, 16'sd50);
        // Zero output limit, then a write to an unused index that changes nothing
        add_write(CFG_OUTPUT_LIMIT, 24'h000000);
        add_item_drive(16'sh7FFF, -16'sh8000, 16'sd0);
        add_write(CFG_LAST_SPARE, 24'h007FFF);
        add_item_drive(16'sd1234, 16'sd0, 16'sd0);
        // Zero integral limit holds the integral at zero
        add_write(CFG_OUTPUT_LIMIT, 24'h007FFF);
        add_write(CFG_GAIN_P, 24'h000000);
        add_write(CFG_GAIN_I, 24'h000100);
        add_write(CFG_INTEGRAL_LIMIT, 24'h000000);
        add_item_drive(16'sd500, 16'sd0, 16'sd0);
        add_item_drive(-16'sd500, 16'sd0, 16'sd0);
        // Integral saturating at a small limit
        add_write(CFG_INTEGRAL_LIMIT, 24'd1000);
        add_item(16'sd800, 16'sd0);
        add_item(16'sd800, 16'sd0);
        add_item(-16'sd300, 16'sd0);
        // Derivative term alone, including the widest error step
        add_write(CFG_GAIN_I, 24'h000000);
        add_write(CFG_GAIN_D, 24'h000100);
        add_item(16'sd10, 16'sd0);
        add_item(-16'sd20, 16'sd0);
        add_item(16'sh7FFF, -16'sh8000);
        add_item(-16'sh8000, 16'sh7FFF);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                wait_drained();
                write_register(directed_rows[r].index, directed_rows[r].data);
            end
            else
            begin
                send_sample(directed_rows[r].setpoint, directed_rows[r].measured,
                            directed_rows[r].has_drive, directed_rows[r].drive);
            end
        end

        // Random phases, each with new register settings
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            if (phase == 0)
            begin
                write_register(CFG_GAIN_P, 24'h007FFF);
                write_register(CFG_GAIN_I, 24'h007FFF);
                write_register(CFG_GAIN_D, 24'h007FFF);
                write_register(CFG_INTEGRAL_LIMIT, 24'hFFFFFF);
                write_register(CFG_OUTPUT_LIMIT, 24'h007FFF);
            end
            else if (phase == 1)
            begin
                write_register(CFG_GAIN_P, 24'h008000);
                write_register(CFG_GAIN_I, 24'h008000);
                write_register(CFG_GAIN_D, 24'h008000);
                write_register(CFG_INTEGRAL_LIMIT, random_integral_limit());
                write_register(CFG_OUTPUT_LIMIT, random_output_limit());
            end
            else
            begin
                write_register(CFG_GAIN_P, random_gain());
                write_register(CFG_GAIN_I, random_gain());
                write_register(CFG_GAIN_D, random_gain());
                write_register(CFG_INTEGRAL_LIMIT, random_integral_limit());
                write_register(CFG_OUTPUT_LIMIT, random_output_limit());
            end
            if ($urandom_range(2) == 0)
                write_register(CFG_FIRST_SPARE
                               + CFG_IDX_W'($urandom_range(CFG_LAST_SPARE
                                                           - CFG_FIRST_SPARE)),
                               CFG_DATA_W'($urandom));

            // One phase runs with both streams always ready
            no_idle = (phase == 5);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (phase == 3 && k == 10)
                    holds_asked++;
                if ($urandom_range(3) == 0)
                begin
                    setpoint = VALUE_W'($urandom);
                    measured = VALUE_W'($urandom);
                end
                else
                begin
                    // Measurement tracking the setpoint closely
                    setpoint = VALUE_W'($urandom);
                    measured = setpoint + VALUE_W'($signed($urandom_range(600)) - 300);
                end
                send_sample(setpoint, measured, 1'b0, '0);
            end
            no_idle = 1'b0;
        end

        // Drain and let the pipeline settle
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_drives.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ppid_pkg.sv
rtl/ppid_cfg.sv
rtl/ppid_error.sv
rtl/ppid_mult.sv
rtl/ppid_out.sv
rtl/positional_pid_controller.sv
tb/sv/tb_positional_pid_controller.sv
